// ===== design/fixed_point_index_range_search_assert.svh =====
// Assertion macros for the fixed-point index range search block.
// Each macro expands to nothing when SYNTH is defined.
`ifndef FIXED_POINT_INDEX_RANGE_SEARCH_ASSERT_SVH
`define FIXED_POINT_INDEX_RANGE_SEARCH_ASSERT_SVH
`ifndef SYNTH
`define FPIRS_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define FPIRS_NEVER(lbl, ck, rn, cond, msg) \
	`FPIRS_ASSERT(lbl, ck, rn, !(cond), msg)
`else
`define FPIRS_ASSERT(lbl, ck, rn, prop, msg)
`define FPIRS_NEVER(lbl, ck, rn, cond, msg)
`endif
`endif

// ===== design/fpirs_pkg.sv =====
package fpirs_pkg;

	localparam int VALUE_W = 32;
	localparam int IDX_W   = 10;

	typedef enum logic [3:0] {
		S_LOAD = 4'b0001,
		S_ADDR = 4'b0010,
		S_CMP  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic issue;
		logic compare;
		logic next_pass;
		logic publish;
	} ctl_cmd_t;

	typedef struct packed {
		logic live;
		logic pass_right;
		logic out_busy;
	} ctl_sts_t;

endpackage

// ===== design/fpirs_ram.sv =====
module fpirs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/fpirs_ctrl.sv =====
module fpirs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                final_element,
	input  fpirs_pkg::ctl_sts_t sts,
	output fpirs_pkg::ctl_cmd_t cmd
);
	import fpirs_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == S_LOAD);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_LOAD: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (final_element) begin
						cmd.start = 1'b1;
						state_d   = S_ADDR;
					end
				end
			end
			S_ADDR: begin
				if (sts.live) begin
					cmd.issue = 1'b1;
					state_d   = S_CMP;
				end else if (!sts.pass_right) begin
					cmd.next_pass = 1'b1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				state_d     = S_ADDR;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.publish = 1'b1;
					state_d     = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/fpirs_datapath.sv =====
module fpirs_datapath #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fpirs_pkg::ctl_cmd_t                  cmd,
	output fpirs_pkg::ctl_sts_t                  sts,
	input  logic signed [fpirs_pkg::VALUE_W-1:0] element_value,
	input  logic                                 final_element,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 found,
	output logic [fpirs_pkg::IDX_W-1:0]          first_index,
	output logic [fpirs_pkg::IDX_W-1:0]          final_index,
	output logic                                 overflowed
);
	import fpirs_pkg::*;

	localparam int AW    = $clog2(MAX_ELEMENTS);
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int IW    = CNT_W + 1;
	localparam int XW    = (AW > IDX_W) ? AW : IDX_W;

	logic [CNT_W-1:0]        count_q;
	logic                    ovf_q;
	logic [VALUE_W-1:0]      first_q;
	logic [VALUE_W-1:0]      last_q;
	logic [CNT_W-1:0]        n_q;
	logic                    asc_q;
	logic                    ovf_res_q;
	logic signed [IW-1:0]    lo_q;
	logic signed [IW-1:0]    hi_q;
	logic [AW-1:0]           mid_q;
	logic                    pass_q;
	logic                    hit_l_q;
	logic                    hit_r_q;
	logic [IDX_W-1:0]        left_q;
	logic [IDX_W-1:0]        right_q;
	logic                    out_valid_q;
	logic                    found_q;
	logic [IDX_W-1:0]        first_index_q;
	logic [IDX_W-1:0]        final_index_q;
	logic                    overflowed_q;

	logic                    store;
	logic [CNT_W-1:0]        n_next;
	logic signed [IW-1:0]    hi_init;
	logic signed [VALUE_W-1:0] first_v;
	logic signed [VALUE_W-1:0] last_v;
	logic signed [IW:0]      mid_sum;
	logic [AW-1:0]           mid_d;
	logic [VALUE_W-1:0]      rd_data;
	logic signed [VALUE_W:0] v_ext;
	logic signed [VALUE_W:0] mid_ext;
	logic                    v_eq;
	logic                    v_lt;
	logic signed [IW-1:0]    mid_p1;
	logic signed [IW-1:0]    mid_m1;
	logic [XW-1:0]           mid_wide;

	assign store   = cmd.load && (count_q < CNT_W'(MAX_ELEMENTS));
	assign n_next  = count_q + CNT_W'(store);
	assign hi_init = $signed(IW'(n_next)) - $signed(IW'(1));

	// The first element of the set may be the one arriving in this beat.
	assign first_v = (count_q == '0) ? element_value : $signed(first_q);
	// When the beat is dropped, the last element is the last one stored.
	assign last_v  = store ? element_value : $signed(last_q);

	assign mid_sum = {lo_q[IW-1], lo_q} + {hi_q[IW-1], hi_q};
	assign mid_d   = mid_sum[AW:1];

	assign v_ext   = {rd_data[VALUE_W-1], rd_data};
	assign mid_ext = $signed((VALUE_W + 1)'(mid_q));
	assign v_eq    = (v_ext == mid_ext);
	assign v_lt    = (v_ext < mid_ext);
	assign mid_p1  = $signed(IW'(mid_q)) + $signed(IW'(1));
	assign mid_m1  = $signed(IW'(mid_q)) - $signed(IW'(1));
	assign mid_wide = XW'(mid_q);

	fpirs_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(MAX_ELEMENTS),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (store),
		.waddr(count_q[AW-1:0]),
		.wdata(element_value),
		.raddr(mid_d),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (final_element) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					count_q <= n_next;
					ovf_q   <= ovf_q | !store;
				end
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			last_q <= element_value;
			if (count_q == '0) begin
				first_q <= element_value;
			end
		end
		if (cmd.start) begin
			n_q       <= n_next;
			asc_q     <= (first_v < last_v);
			ovf_res_q <= ovf_q | !store;
			lo_q      <= '0;
			hi_q      <= hi_init;
			pass_q    <= 1'b0;
			hit_l_q   <= 1'b0;
			hit_r_q   <= 1'b0;
			left_q    <= '0;
			right_q   <= '0;
		end
		if (cmd.next_pass) begin
			lo_q   <= '0;
			hi_q   <= $signed(IW'(n_q)) - $signed(IW'(1));
			pass_q <= 1'b1;
		end
		if (cmd.issue) begin
			mid_q <= mid_d;
		end
		if (cmd.compare) begin
			if (v_eq) begin
				if (!pass_q) begin
					hit_l_q <= 1'b1;
					left_q  <= mid_wide[IDX_W-1:0];
					hi_q    <= mid_m1;
				end else begin
					hit_r_q <= 1'b1;
					right_q <= mid_wide[IDX_W-1:0];
					lo_q    <= mid_p1;
				end
			end else if (v_lt == asc_q) begin
				lo_q <= mid_p1;
			end else begin
				hi_q <= mid_m1;
			end
		end
		if (cmd.publish) begin
			found_q       <= hit_l_q | hit_r_q;
			first_index_q <= left_q;
			final_index_q <= right_q;
			overflowed_q  <= ovf_res_q;
		end
	end

	assign sts.live       = (lo_q <= hi_q);
	assign sts.pass_right = pass_q;
	assign sts.out_busy   = out_valid_q && !out_ready;

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign first_index = first_index_q;
	assign final_index = final_index_q;
	assign overflowed  = overflowed_q;

endmodule

// ===== design/fixed_point_index_range_search.sv =====
// Loads a set of signed 32-bit elements, one per beat, into a store of MAX_ELEMENTS
// entries, and on the beat marked final_element searches it for the leftmost and
// rightmost index whose element equals the index (ascending if the first element is
// below the last, descending otherwise), then returns one result. Load beats are taken
// one per cycle, also while an earlier result waits on the output. The final beat
// starts two binary searches over the n elements held; each probe has an address step, then the
// registered read of the simple dual-port store and its compare. No beat is taken while the
// search runs. Beats beyond MAX_ELEMENTS are dropped and reported by overflowed.
// Indices are reported in 10 bits (low bits when MAX_ELEMENTS exceeds 1024).
`include "fixed_point_index_range_search_assert.svh"

module fixed_point_index_range_search #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [fpirs_pkg::VALUE_W-1:0] element_value,
	input  logic                                 final_element,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 found,
	output logic [fpirs_pkg::IDX_W-1:0]          first_index,
	output logic [fpirs_pkg::IDX_W-1:0]          final_index,
	output logic                                 overflowed
);
	import fpirs_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	fpirs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.final_element(final_element),
		.sts          (sts),
		.cmd          (cmd)
	);

	fpirs_datapath #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.element_value(element_value),
		.final_element(final_element),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.first_index  (first_index),
		.final_index  (final_index),
		.overflowed   (overflowed)
	);

	// A final beat must start the search and close the input.
	`FPIRS_ASSERT(a_final_closes_input, clk, arst_n, in_valid && in_ready && final_element |=> !in_ready, "input still open after final beat")
	// A result may only be written into a free output register.
	`FPIRS_NEVER(a_publish_into_busy, clk, arst_n, cmd.publish && out_valid && !out_ready, "result overwrote a pending result")
	// Without a match both indices read as zero.
	`FPIRS_ASSERT(a_no_match_zero, clk, arst_n, out_valid && !found |-> first_index == '0 && final_index == '0, "nonzero index without a match")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int STORE_DEPTH  = 1024;
	localparam int PHASE_ITEMS  = 230;
	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT  = 500000;

	localparam logic [31:0] MOST_NEG  = 32'h8000_0000;
	localparam logic [31:0] MOST_POS  = 32'h7fff_ffff;
	localparam logic [31:0] MINUS_ONE = 32'hffff_ffff;

	typedef enum int {
		SHAPE_PLATEAU,
		SHAPE_DESCEND,
		SHAPE_WIDE,
		SHAPE_BROKEN,
		SHAPE_NOISE
	} set_shape_t;

	typedef struct packed {
		logic                           found;
		logic [fpirs_pkg::IDX_W-1:0]    first_idx;
		logic [fpirs_pkg::IDX_W-1:0]    last_idx;
		logic                           ovf;
	} search_outcome_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_ready;
	logic signed [fpirs_pkg::VALUE_W-1:0] element_value;
	logic                                 final_element;
	logic                                 out_valid;
	logic                                 out_ready;
	logic                                 found;
	logic [fpirs_pkg::IDX_W-1:0]          first_index;
	logic [fpirs_pkg::IDX_W-1:0]          final_index;
	logic                                 overflowed;

	int send_idle_pct;
	int recv_stall_pct;
	int cycle_count;

	// Mirrors the element store and predicts the outcome of every set.
	class fixed_point_tracker;
		int              held [STORE_DEPTH];
		int              held_count;
		bit              dropped;
		search_outcome_t pending_outcomes [$];
		int              errors;
		int              outcomes_checked;
		int              elements_loaded;
		int              overflow_sets;
		int              hit_sets;

		function new();
			held_count       = 0;
			dropped          = 0;
			errors           = 0;
			outcomes_checked = 0;
			elements_loaded  = 0;
			overflow_sets    = 0;
			hit_sets         = 0;
		endfunction

		function bit find_fixed_point(int n, bit ascending, bit leftmost, output longint hit);
			longint lo, hi, mid, probe;
			bit     got;
			lo  = 0;
			hi  = n - 1;
			got = 0;
			hit = 0;
			while (lo <= hi) begin
				mid   = (lo + hi) / 2;
				probe = held[mid];
				if (probe == mid) begin
					hit = mid;
					got = 1;
					if (leftmost)
						hi = mid - 1;
					else
						lo = mid + 1;
				end else if ((probe < mid) == ascending) begin
					lo = mid + 1;
				end else begin
					hi = mid - 1;
				end
			end
			return got;
		endfunction

		function void load_element(logic signed [31:0] value, logic last);
			search_outcome_t expected;
			longint          left, right;
			bit              ascending, hit_l, hit_r;
			elements_loaded++;
			if (held_count < STORE_DEPTH) begin
				held[held_count] = value;
				held_count++;
			end else begin
				dropped = 1;
			end
			if (last) begin
				// A single element compares equal to itself, so it counts as descending.
				ascending          = held[0] < held[held_count - 1];
				hit_l              = find_fixed_point(held_count, ascending, 1'b1, left);
				hit_r              = find_fixed_point(held_count, ascending, 1'b0, right);
				expected.found     = hit_l || hit_r;
				expected.first_idx = hit_l ? left[9:0] : '0;
				expected.last_idx  = hit_r ? right[9:0] : '0;
				expected.ovf       = dropped;
				pending_outcomes.push_back(expected);
				if (expected.found)
					hit_sets++;
				if (dropped)
					overflow_sets++;
				held_count = 0;
				dropped    = 0;
			end
		endfunction

		function void compare_field(string field, logic [9:0] want, logic [9:0] seen);
			if (seen !== want) begin
				errors++;
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, seen);
			end
		endfunction

		function void check_outcome(logic got_found, logic [9:0] got_first,
				logic [9:0] got_last, logic got_ovf);
			search_outcome_t expected;
			if (pending_outcomes.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, got found=%b first=%0d last=%0d overflowed=%b",
					$time, got_found, got_first, got_last, got_ovf);
				return;
			end
			expected = pending_outcomes.pop_front();
			outcomes_checked++;
			compare_field("found", 10'(expected.found), 10'(got_found));
			compare_field("first_index", expected.first_idx, got_first);
			compare_field("final_index", expected.last_idx, got_last);
			compare_field("overflowed", 10'(expected.ovf), 10'(got_ovf));
		endfunction
	endclass

	fixed_point_tracker tracker;

	fixed_point_index_range_search #(
		.MAX_ELEMENTS(STORE_DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.element_value(element_value),
		.final_element(final_element),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.first_index  (first_index),
		.final_index  (final_index),
		.overflowed   (overflowed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				tracker.check_outcome(found, first_index, final_index, overflowed);
			if (in_valid && in_ready)
				tracker.load_element(element_value, final_element);
		end
	end

	// Entered right after the edge that took the previous beat.
	task automatic send_element(input logic [31:0] value, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid      <= 1'b1;
		element_value <= value;
		final_element <= last;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic run_set(input set_shape_t shape, input int len);
		longint vals [];
		int     lo_fix, hi_fix, slope_lo, slope_hi;
		longint acc;
		bit     rising;
		vals = new[len];
		case (shape)
			SHAPE_PLATEAU, SHAPE_BROKEN: begin
				// Strictly rising values with a run of fixed points, sometimes empty.
				lo_fix   = $urandom_range(0, len - 1);
				hi_fix   = ($urandom_range(0, 4) == 0) ? lo_fix - 1 : $urandom_range(lo_fix, len - 1);
				slope_lo = $urandom_range(0, 3);
				slope_hi = $urandom_range(0, 3);
				for (int i = 0; i < len; i++) begin
					if (i < lo_fix)
						vals[i] = i - 1 - (lo_fix - 1 - i) * slope_lo;
					else if (i <= hi_fix)
						vals[i] = i;
					else
						vals[i] = i + 1 + (i - hi_fix - 1) * slope_hi;
				end
				if (shape == SHAPE_BROKEN)
					vals[$urandom_range(0, len - 1)] = longint'($signed($urandom));
			end
			SHAPE_DESCEND: begin
				acc = longint'($urandom_range(0, len + 2)) - 2;
				for (int i = 0; i < len; i++) begin
					vals[i] = acc;
					acc -= $urandom_range(0, 3);
				end
			end
			SHAPE_WIDE: begin
				acc    = longint'($signed($urandom));
				rising = $urandom_range(0, 1);
				for (int i = 0; i < len; i++) begin
					vals[i] = acc;
					if (rising) begin
						acc += $urandom_range(0, 1 << 20);
						if (acc > longint'($signed(MOST_POS)))
							acc = longint'($signed(MOST_POS));
					end else begin
						acc -= $urandom_range(0, 1 << 20);
						if (acc < longint'($signed(MOST_NEG)))
							acc = longint'($signed(MOST_NEG));
					end
				end
			end
			default: begin
				for (int i = 0; i < len; i++) begin
					case ($urandom_range(0, 5))
						0: vals[i] = longint'($signed(MOST_NEG));
						1: vals[i] = longint'($signed(MOST_POS));
						2: vals[i] = $urandom_range(0, len);
						default: vals[i] = longint'($signed($urandom));
					endcase
				end
			end
		endcase
		for (int i = 0; i < len; i++)
			send_element(vals[i][31:0], i == len - 1);
	endtask

	initial begin : stimulus
		int         budget, len, pick;
		set_shape_t shape;
		tracker        = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		element_value  = '0;
		final_element  = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Single elements: only index 0 is probed.
		send_element(32'd0, 1'b1);
		send_element(32'd5, 1'b1);
		send_element(MOST_NEG, 1'b1);
		send_element(MOST_POS, 1'b1);
		// Every index is a fixed point.
		send_element(32'd0, 1'b0);
		send_element(32'd1, 1'b0);
		send_element(32'd2, 1'b0);
		send_element(32'd3, 1'b1);
		// Descending through both extremes with one fixed point.
		send_element(MOST_POS, 1'b0);
		send_element(32'd5, 1'b0);
		send_element(32'd2, 1'b0);
		send_element(MOST_NEG, 1'b1);
		// Ascending through both extremes with no fixed point.
		send_element(MOST_NEG, 1'b0);
		send_element(32'd0, 1'b0);
		send_element(MOST_POS, 1'b1);
		// Equal ends count as descending, then an ascending set that starts at minus one.
		send_element(32'd7, 1'b0);
		send_element(32'd7, 1'b1);
		send_element(MINUS_ONE, 1'b0);
		send_element(32'd1, 1'b0);
		send_element(32'd5, 1'b0);
		send_element(32'd9, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 60;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 60;
				end
				default: begin
					send_idle_pct  = 13;
					recv_stall_pct = 13;
				end
			endcase
			// A set that fills the store and runs past its capacity.
			if (ph == 2)
				run_set(SHAPE_PLATEAU, STORE_DEPTH + $urandom_range(1, 6));
			budget = 0;
			while (budget < PHASE_ITEMS) begin
				len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
				pick = $urandom_range(0, 99);
				if (pick < 35)
					shape = SHAPE_PLATEAU;
				else if (pick < 60)
					shape = SHAPE_DESCEND;
				else if (pick < 70)
					shape = SHAPE_WIDE;
				else if (pick < 85)
					shape = SHAPE_BROKEN;
				else
					shape = SHAPE_NOISE;
				run_set(shape, len);
				budget += len;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Loaded %0d elements and checked %0d search outcomes under four idle patterns.",
			tracker.elements_loaded, tracker.outcomes_checked);
		$display("%0d sets held a fixed point, %0d overflowed the store.",
			tracker.hit_sets, tracker.overflow_sets);
		if (tracker.errors == 0 && tracker.pending_outcomes.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
